// ===== hdl/rms_pkg.sv =====
`default_nettype none

package rms_pkg;

  // fixed field widths
  localparam int unsigned POS_W  = 11;
  localparam int unsigned VAL_W  = 20;
  localparam int unsigned NODE_W = 21;

  typedef logic signed [NODE_W-1:0] node_t;

  // all ones marks an empty span
  localparam node_t EMPTY_NODE = '1;

  typedef enum logic [1:0] {
    OP_UPDATE = 2'd0,
    OP_QUERY  = 2'd1,
    OP_CLEAR  = 2'd2
  } opcode_t;

  // one input word after unpacking
  typedef struct packed {
    opcode_t            opcode;
    logic [POS_W-1:0]   position;
    logic [VAL_W-1:0]   new_value;
    logic [POS_W-1:0]   range_first;
    logic [POS_W-1:0]   range_last;
  } item_t;

  // signed maximum of two nodes
  function automatic node_t smax(input node_t a, input node_t b);
    return (a > b) ? a : b;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/rms_node_mem.sv =====
`default_nettype none

module rms_node_mem
  import rms_pkg::*;
#(
  parameter int unsigned DEPTH = 2048,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  wire logic          clk,
  input  wire logic [AW-1:0] rd_addr,
  output node_t              rd_data,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire node_t         wr_data
);

  node_t mem [DEPTH];

  // one write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // one registered read port
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

// ===== hdl/rms_ctrl.sv =====
`default_nettype none

module rms_ctrl
  import rms_pkg::*;
#(
  parameter int unsigned LEAVES = 1024,
  localparam int unsigned AW = $clog2(2 * LEAVES),
  localparam int unsigned CW = ((AW + 1) > POS_W) ? (AW + 1) : POS_W
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic [CW-1:0] positions_in_use,
  input  wire logic          item_valid,
  output logic               item_ready,
  input  wire item_t         item,
  input  wire logic          out_free,
  output logic               res_valid,
  output node_t              res_value,
  output logic [AW-1:0]      rd_addr,
  input  wire node_t         rd_data,
  output logic               wr_en,
  output logic [AW-1:0]      wr_addr,
  output node_t              wr_data
);

  localparam logic [AW-1:0] LAST_ADDR = AW'(2 * LEAVES - 1);
  localparam logic [CW-1:0] LEAVES_W  = CW'(LEAVES);
  localparam logic [CW-1:0] ONE_W     = CW'(1);

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_U_RD,
    S_U_WR,
    S_U_SIB_RD,
    S_U_SIB_WR,
    S_Q_TEST,
    S_Q_HI,
    S_Q_FOLD,
    S_Q_OUT
  } state_t;

  state_t           state;
  logic [AW-1:0]    clr_addr;
  logic [AW-1:0]    k;
  logic [VAL_W-1:0] val;
  node_t            cur;
  node_t            best;
  logic [CW-1:0]    lo;
  logic [CW-1:0]    hi;
  logic             pend;

  logic [CW-1:0]    used_w;
  logic [CW-1:0]    pos_w;
  logic [CW-1:0]    first_w;
  logic [CW-1:0]    last_w;
  logic [CW-1:0]    leaf_w;
  logic [CW-1:0]    qlo_w;
  logic [CW-1:0]    qhi_w;
  logic [CW-1:0]    hi_dec;
  logic             upd_ok;
  logic             q_empty;
  logic [AW-1:0]    parent;
  node_t            leaf_max;
  node_t            sib_max;

  // decode of an incoming word against the positions in use
  always_comb begin
    used_w  = (positions_in_use > LEAVES_W) ? LEAVES_W : positions_in_use;
    pos_w   = CW'(item.position);
    first_w = (item.range_first == '0) ? ONE_W : CW'(item.range_first);
    last_w  = (CW'(item.range_last) > used_w) ? used_w : CW'(item.range_last);
    upd_ok  = (pos_w != '0) && (pos_w <= used_w);
    q_empty = (used_w == '0) || (first_w > last_w);
    leaf_w  = LEAVES_W + pos_w - ONE_W;
    qlo_w   = LEAVES_W + first_w - ONE_W;
    qhi_w   = LEAVES_W + last_w;
  end

  // datapath helpers
  always_comb begin
    hi_dec   = hi - ONE_W;
    parent   = k >> 1;
    leaf_max = smax(rd_data, node_t'({1'b0, val}));
    sib_max  = smax(cur, rd_data);
  end

  // memory read address; each read is registered and consumed in the cycle after it
  always_comb begin
    unique case (state)
      S_U_SIB_RD: rd_addr = k ^ AW'(1);
      S_Q_TEST:   rd_addr = lo[AW-1:0];
      S_Q_HI:     rd_addr = hi_dec[AW-1:0];
      default:    rd_addr = k;
    endcase
  end

  // memory write port; the leaf write targets the same entry that the read port addresses in that step
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = k;
    wr_data = leaf_max;
    unique case (state)
      S_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_addr;
        wr_data = EMPTY_NODE;
      end
      S_U_WR: begin
        wr_en = 1'b1;
      end
      S_U_SIB_WR: begin
        wr_en   = 1'b1;
        wr_addr = parent;
        wr_data = sib_max;
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  assign item_ready = (state == S_IDLE);
  assign res_valid  = (state == S_Q_OUT) && out_free;
  assign res_value  = best;

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr_addr <= '0;
    end else begin
      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + AW'(1);
          if (clr_addr == LAST_ADDR) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (item_valid) begin
            unique case (item.opcode)
              OP_UPDATE: begin
                if (upd_ok) begin
                  k     <= leaf_w[AW-1:0];
                  val   <= item.new_value;
                  state <= S_U_RD;
                end
              end
              OP_QUERY: begin
                best  <= EMPTY_NODE;
                lo    <= qlo_w;
                hi    <= qhi_w;
                state <= q_empty ? S_Q_OUT : S_Q_TEST;
              end
              OP_CLEAR: begin
                clr_addr <= '0;
                state    <= S_CLEAR;
              end
              default: begin
                state <= S_IDLE;
              end
            endcase
          end
        end
        // leaf merge, then one sibling read and parent write per level
        S_U_RD: begin
          state <= S_U_WR;
        end
        S_U_WR: begin
          cur   <= leaf_max;
          state <= S_U_SIB_RD;
        end
        S_U_SIB_RD: begin
          state <= S_U_SIB_WR;
        end
        S_U_SIB_WR: begin
          cur <= sib_max;
          k   <= parent;
          if (parent == AW'(1)) begin
            state <= S_IDLE;
          end else begin
            state <= S_U_SIB_RD;
          end
        end
        // bottom-up range walk, left edge then right edge per level
        S_Q_TEST: begin
          if (lo < hi) begin
            pend <= lo[0];
            if (lo[0]) begin
              lo <= lo + ONE_W;
            end
            state <= S_Q_HI;
          end else begin
            state <= S_Q_OUT;
          end
        end
        S_Q_HI: begin
          if (pend) begin
            best <= smax(best, rd_data);
          end
          if (hi[0]) begin
            hi    <= hi_dec;
            state <= S_Q_FOLD;
          end else begin
            lo    <= lo >> 1;
            hi    <= hi >> 1;
            state <= S_Q_TEST;
          end
        end
        S_Q_FOLD: begin
          best  <= smax(best, rd_data);
          lo    <= lo >> 1;
          hi    <= hi >> 1;
          state <= S_Q_TEST;
        end
        S_Q_OUT: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== hdl/range_max_segment_tree.sv =====
// Range-maximum tree over leaf positions 1..positions_in_use, kept in one
// single-port-read node memory of 2*LEAVES entries with a registered read.
// Each operation is run by a sequencer that reads, merges and writes nodes
// one at a time. An update makes one read and one write per tree level. A
// query reads one or two nodes per level it climbs and may then wait for the
// output register to free up. A clear, and likewise the start after reset,
// sweeps all 2*LEAVES nodes one node a cycle, during which no input word is
// accepted. Words with no result (update, clear, unknown opcode) return no
// output word. The positions_in_use register may be written at any idle time.
`default_nettype none

module range_max_segment_tree
  import rms_pkg::*;
#(
  parameter int unsigned LEAVES = 1024
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             cfg_wr_en,
  input  wire logic [POS_W-1:0] cfg_wr_data,   // positions_in_use
  input  wire logic             s_axis_tvalid,
  output logic                  s_axis_tready,
  input  wire logic [55:0]      s_axis_tdata,  // position, new_value, range_first, range_last
  input  wire logic [1:0]       s_axis_tuser,  // opcode
  output logic                  m_axis_tvalid,
  input  wire logic             m_axis_tready,
  output logic [23:0]           m_axis_tdata   // range_maximum
);

  localparam int unsigned DEPTH = 2 * LEAVES;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned CW    = ((AW + 1) > POS_W) ? (AW + 1) : POS_W;

  logic [CW-1:0] positions_in_use;
  item_t         item;
  logic          out_free;
  logic          res_valid;
  node_t         res_value;
  node_t         out_value;
  logic [AW-1:0] rd_addr;
  node_t         rd_data;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  node_t         wr_data;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      positions_in_use <= CW'(LEAVES);
    end else if (cfg_wr_en) begin
      positions_in_use <= CW'(cfg_wr_data);
    end
  end

  // unpack input word
  always_comb begin
    item.opcode      = opcode_t'(s_axis_tuser);
    item.position    = s_axis_tdata[10:0];
    item.new_value   = s_axis_tdata[30:11];
    item.range_first = s_axis_tdata[41:31];
    item.range_last  = s_axis_tdata[52:42];
  end

  // output register
  assign out_free = !m_axis_tvalid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (res_valid) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      out_value <= res_value;
    end
  end

  assign m_axis_tdata = {3'b000, out_value};

  rms_ctrl #(
    .LEAVES (LEAVES)
  ) u_ctrl (
    .clk              (clk),
    .rst              (rst),
    .positions_in_use (positions_in_use),
    .item_valid       (s_axis_tvalid),
    .item_ready       (s_axis_tready),
    .item             (item),
    .out_free         (out_free),
    .res_valid        (res_valid),
    .res_value        (res_value),
    .rd_addr          (rd_addr),
    .rd_data          (rd_data),
    .wr_en            (wr_en),
    .wr_addr          (wr_addr),
    .wr_data          (wr_data)
  );

  rms_node_mem #(
    .DEPTH (DEPTH)
  ) u_mem (
    .clk     (clk),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

endmodule

`default_nettype wire

// ===== tb/sv/range_max_segment_tree_test.sv =====
module range_max_segment_tree_test;
  import rms_pkg::*;

  localparam int unsigned LEAVES = 1024;
  // a clear sweeps every node once, the slowest thing the block does
  localparam int unsigned SWEEP_CYCLES = 2 * LEAVES + 64;
  localparam int unsigned TAIL_CYCLES = 200;
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam logic [VAL_W-1:0] VAL_TOP = '1;
  localparam logic [POS_W-1:0] POS_TOP = '1;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_wr_en = 1'b0;
  logic [POS_W-1:0] cfg_wr_data = '0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [55:0] s_axis_tdata = '0;  // position, new_value, range_first, range_last
  logic [1:0] s_axis_tuser = '0;   // opcode
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;       // range_maximum

  range_max_segment_tree #(
    .LEAVES(LEAVES)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  always #10 clk = ~clk;

  // shadow tree and register
  node_t tree_max [2*LEAVES];
  logic [POS_W-1:0] positions_limit;

  item_t pending_words[$];
  node_t max_answers[$];
  item_t next_word;
  bit idle_on = 1'b1;
  int unsigned send_gap = 0;
  int unsigned recv_gap = 0;
  int unsigned stall;
  node_t want;
  int unsigned mismatches = 0;

  function automatic int unsigned live_positions();
    return (positions_limit > LEAVES) ? LEAVES : positions_limit;
  endfunction

  task automatic clear_tree();
    foreach (tree_max[i]) tree_max[i] = EMPTY_NODE;
  endtask

  // merge into one leaf, then refresh every ancestor
  task automatic raise_leaf(int unsigned pos, node_t v);
    int unsigned k;
    k = LEAVES + pos - 1;
    if (v > tree_max[k]) tree_max[k] = v;
    while (k > 1) begin
      k = k >> 1;
      tree_max[k] = (tree_max[2*k] > tree_max[2*k+1]) ? tree_max[2*k] : tree_max[2*k+1];
    end
  endtask

  // bottom-up walk over the half-open node span
  function automatic node_t span_max(int unsigned first, int unsigned last);
    node_t best;
    int unsigned lo, hi;
    best = EMPTY_NODE;
    lo = LEAVES + first - 1;
    hi = LEAVES + last;
    while (lo < hi) begin
      if (lo[0]) begin
        if (tree_max[lo] > best) best = tree_max[lo];
        lo++;
      end
      if (hi[0]) begin
        hi--;
        if (tree_max[hi] > best) best = tree_max[hi];
      end
      lo = lo >> 1;
      hi = hi >> 1;
    end
    return best;
  endfunction

  // apply one accepted word to the shadow tree
  task automatic accept_word(logic [1:0] op, logic [55:0] data);
    logic [POS_W-1:0] pos, first, last;
    logic [VAL_W-1:0] val;
    int unsigned span, lo, hi;
    pos = data[10:0];
    val = data[30:11];
    first = data[41:31];
    last = data[52:42];
    span = live_positions();
    case (op)
      OP_UPDATE: begin
        if (pos >= 1 && pos <= span) raise_leaf(pos, node_t'({1'b0, val}));
      end
      OP_QUERY: begin
        lo = (first == 0) ? 1 : first;
        hi = (last > span) ? span : last;
        if (span == 0 || lo > hi) max_answers.push_back(EMPTY_NODE);
        else max_answers.push_back(span_max(lo, hi));
      end
      OP_CLEAR: clear_tree();
      default: ;
    endcase
  endtask

  task automatic report_mismatch(string what);
    $display("mismatch at %0t: %s", $time, what);
    mismatches++;
  endtask

  task automatic push_word(logic [1:0] op, int unsigned pos, int unsigned val,
                           int unsigned first, int unsigned last);
    item_t w;
    w.opcode = opcode_t'(op);
    w.position = POS_W'(pos);
    w.new_value = VAL_W'(val);
    w.range_first = POS_W'(first);
    w.range_last = POS_W'(last);
    pending_words.push_back(w);
  endtask

  // mostly in-range updates and queries, some wild fields, rare clears
  function automatic item_t random_word(int unsigned span);
    item_t w;
    int unsigned pick, a, b;
    pick = $urandom_range(0, 99);
    w.opcode = OP_UPDATE;
    w.position = POS_W'($urandom_range(0, 2047));
    w.range_first = POS_W'($urandom_range(0, 2047));
    w.range_last = POS_W'($urandom_range(0, 2047));
    case ($urandom_range(0, 9))
      0: w.new_value = VAL_TOP;
      1: w.new_value = VAL_W'($urandom_range(0, 15));
      default: w.new_value = VAL_W'($urandom_range(0, 1048575));
    endcase
    if (pick < 50) begin
      if (span > 0 && $urandom_range(0, 9) != 0) w.position = POS_W'($urandom_range(1, span));
    end else if (pick < 93) begin
      w.opcode = OP_QUERY;
      if (span > 0 && $urandom_range(0, 4) != 0) begin
        a = $urandom_range(1, span);
        b = ($urandom_range(0, 2) == 0) ? a + $urandom_range(0, 3) : $urandom_range(1, span);
        if (b > span) b = span;
        w.range_first = POS_W'((a < b) ? a : b);
        w.range_last = POS_W'((a < b) ? b : a);
        if ($urandom_range(0, 15) == 0) w.range_first = '0;
      end
    end else if (pick < 95) begin
      w.opcode = OP_CLEAR;
    end else begin
      w.opcode = opcode_t'(OP_UNUSED);
    end
    return w;
  endfunction

  // hold off until every word is sent and answered, then let the block settle
  task automatic wait_drained(int unsigned tail);
    do @(negedge clk);
    while (pending_words.size() != 0 || s_axis_tvalid || max_answers.size() != 0);
    repeat (tail) @(posedge clk);
  endtask

  task automatic run_phase(logic [POS_W-1:0] limit, int unsigned n, bit idle);
    wait_drained(SWEEP_CYCLES);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= limit;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(negedge clk);
    positions_limit = limit;
    idle_on = idle;
    repeat (n) pending_words.push_back(random_word(live_positions()));
  endtask

  // sender: one word per handshake, with a random gap before the next when idle_on is set
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      send_gap <= 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) accept_word(s_axis_tuser, s_axis_tdata);
      if (!s_axis_tvalid || s_axis_tready) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          s_axis_tvalid <= 1'b0;
        end else if (pending_words.size() > 0) begin
          next_word = pending_words.pop_front();
          s_axis_tdata <= {3'b000, next_word.range_last, next_word.range_first,
                           next_word.new_value, next_word.position};
          s_axis_tuser <= next_word.opcode;
          s_axis_tvalid <= 1'b1;
          send_gap <= idle_on ? $urandom_range(0, 9) : 0;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver: check each result word, then stall at random when idle_on is set
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
      recv_gap <= 0;
    end else if (m_axis_tvalid && m_axis_tready) begin
      if (max_answers.size() == 0) begin
        report_mismatch($sformatf("result word %h with no query pending", m_axis_tdata));
      end else begin
        want = max_answers.pop_front();
        if (m_axis_tdata[20:0] !== want)
          report_mismatch($sformatf("range_maximum %0d, want %0d",
                                    $signed(m_axis_tdata[20:0]), want));
        if (m_axis_tdata[23:21] !== 3'b000)
          report_mismatch($sformatf("padding bits %b not zero", m_axis_tdata[23:21]));
      end
      stall = idle_on ? $urandom_range(0, 9) : 0;
      recv_gap <= stall;
      m_axis_tready <= (stall == 0);
    end else if (recv_gap > 0) begin
      recv_gap <= recv_gap - 1;
      m_axis_tready <= (recv_gap == 1);
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // stimulus
  initial begin
    positions_limit = POS_W'(LEAVES);
    clear_tree();
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);
    // empty tree, then the value extremes at the end leaves
    push_word(OP_QUERY, 0, 0, 1, LEAVES);
    push_word(OP_UPDATE, 1, 0, 0, 0);
    push_word(OP_UPDATE, LEAVES, VAL_TOP, POS_TOP, POS_TOP);
    // position zero and beyond the leaves are dropped
    push_word(OP_UPDATE, 0, 5, 0, 0);
    push_word(OP_UPDATE, POS_TOP, 7, 0, 0);
    // a smaller value does not lower a leaf
    push_word(OP_UPDATE, 512, 100, 0, 0);
    push_word(OP_UPDATE, 512, 50, 0, 0);
    push_word(OP_QUERY, 0, 0, 1, LEAVES);
    push_word(OP_QUERY, 0, 0, 0, 1);
    push_word(OP_QUERY, 0, 0, 2, LEAVES - 1);
    push_word(OP_QUERY, 0, 0, 512, 512);
    // reversed, clipped and empty-after-clip ranges
    push_word(OP_QUERY, 0, 0, LEAVES, 1);
    push_word(OP_QUERY, 0, 0, 513, POS_TOP);
    push_word(OP_QUERY, 0, 0, POS_TOP, POS_TOP);
    push_word(OP_QUERY, 0, 0, 0, 0);
    push_word(OP_UNUSED, POS_TOP, VAL_TOP, POS_TOP, POS_TOP);
    push_word(OP_CLEAR, 0, 0, 0, 0);
    push_word(OP_QUERY, 0, 0, 1, LEAVES);
    push_word(OP_UPDATE, 3, 9, 0, 0);
    push_word(OP_QUERY, 0, 0, 3, 3);
    push_word(OP_QUERY, 0, 0, 1, 2);
    repeat (250) pending_words.push_back(random_word(live_positions()));
    // register settings, stored values carried across each change
    run_phase(0, 40, 1'b1);
    run_phase(1, 60, 1'b0);
    run_phase(POS_TOP, 150, 1'b1);
    run_phase(5, 100, 1'b1);
    run_phase(100, 150, 1'b0);
    run_phase(POS_W'($urandom_range(2, LEAVES - 1)), 150, 1'b1);
    run_phase(POS_W'(LEAVES), 150, 1'b1);
    wait_drained(TAIL_CYCLES);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // watchdog
  initial begin
    #24_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
